// ===== design/bbd_pkg.sv =====
package bbd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int AW         = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 13;
  localparam int STEP_W     = 18;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 16;
  localparam int GSUM_W     = 32;
  localparam int GCNT_W     = 25;
  localparam int BAND_W     = 13;
  localparam int OCOORD_W   = 12;
  localparam int CIDX_W     = 3;
  localparam int CDATA_W    = 18;
  localparam int DIVC_W     = $clog2(GSUM_W);

  localparam logic [STEP_W-1:0] PHASE_ONE = STEP_W'(18'h20000);

  typedef enum logic [CIDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_COL_STEP   = 3'd4,
    REG_ROW_STEP   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic          clear_wr;
    logic [AW-1:0] clear_addr;
    logic          accept;
    logic          exec;
    logic          div_start;
    logic          div_step;
    logic          out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/bbd_ifs.sv =====
interface bbd_in_if;
  logic                      valid;
  logic                      ready;
  logic [bbd_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bbd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bbd_pkg::PIX_W-1:0]    out_pixel;
  logic [bbd_pkg::OCOORD_W-1:0] out_col;
  logic [bbd_pkg::OCOORD_W-1:0] out_row;
  logic                         row_end;
  logic                         frame_end;
  modport source (output valid, output out_pixel, output out_col, output out_row,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input out_col, input out_row,
                  input row_end, input frame_end, output ready);
endinterface

interface bbd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bbd_pkg::CIDX_W-1:0]  index;
  logic [bbd_pkg::CDATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bbd_ram.sv =====
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bbd_ctl.sv =====
module bbd_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  bbd_pkg::dp_stat_t stat,
  output logic              in_ready,
  output bbd_pkg::ctl_cmd_t cmd
);
  import bbd_pkg::*;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [DIVC_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == AW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = stat.emit ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_cnt_r == DIVC_W'(GSUM_W - 1)) state_nxt = ST_WAIT;
      ST_WAIT:  if (!stat.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd.clear_wr   = (state_r == ST_CLEAR);
    cmd.clear_addr = clr_addr_r;
    cmd.accept     = (state_r == ST_IDLE) && in_valid;
    cmd.exec       = (state_r == ST_EXEC);
    cmd.div_start  = (state_r == ST_EXEC) && stat.emit;
    cmd.div_step   = (state_r == ST_DIV);
    cmd.out_load   = (state_r == ST_WAIT) && !stat.out_busy;
    clr_addr_nxt   = (state_r == ST_CLEAR) ? clr_addr_r + AW'(1) : clr_addr_r;
    div_cnt_nxt    = (state_r == ST_DIV) ? div_cnt_r + DIVC_W'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

endmodule

// ===== design/bbd_dp.sv =====
module bbd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bbd_pkg::ctl_cmd_t            cmd,
  output bbd_pkg::dp_stat_t            stat,
  input  logic [bbd_pkg::PIX_W-1:0]    in_pixel,
  input  logic                         cfg_we,
  input  logic [bbd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::CDATA_W-1:0]  cfg_data,
  output logic                         ram_we,
  output logic [bbd_pkg::AW-1:0]       ram_waddr,
  output logic [bbd_pkg::SUM_W-1:0]    ram_wdata,
  output logic [bbd_pkg::AW-1:0]       ram_raddr,
  input  logic [bbd_pkg::SUM_W-1:0]    ram_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbd_pkg::PIX_W-1:0]    out_pixel,
  output logic [bbd_pkg::OCOORD_W-1:0] out_col,
  output logic [bbd_pkg::OCOORD_W-1:0] out_row,
  output logic                         row_end,
  output logic                         frame_end
);
  import bbd_pkg::*;

  logic [DIM_W-1:0]  src_w_r, src_w_nxt, src_h_r, src_h_nxt;
  logic [DIM_W-1:0]  dst_w_r, dst_w_nxt, dst_h_r, dst_h_nxt;
  logic [STEP_W-1:0] col_step_r, col_step_nxt, row_step_r, row_step_nxt;

  logic [PIX_W-1:0]  px_r, px_nxt;
  logic [STEP_W-1:0] row_phase_r, row_phase_nxt, col_phase_r, col_phase_nxt;
  logic [AW-1:0]     src_col_r, src_col_nxt;
  logic [ROW_W-1:0]  src_row_r, src_row_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [GSUM_W-1:0] gsum_r, gsum_nxt;
  logic [GCNT_W-1:0] gcnt_r, gcnt_nxt;
  logic [DIM_W-1:0]  dst_col_r, dst_col_nxt, dst_row_r, dst_row_nxt;
  logic              closes_r, closes_nxt;

  logic [GSUM_W-1:0]   num_r, num_nxt;
  logic [GCNT_W-1:0]   den_r, den_nxt, rem_r, rem_nxt;
  logic [OCOORD_W-1:0] m_col_r, m_col_nxt, m_row_r, m_row_nxt;
  logic                m_rend_r, m_rend_nxt, m_fend_r, m_fend_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]    o_pix_r, o_pix_nxt;
  logic [OCOORD_W-1:0] o_col_r, o_col_nxt, o_row_r, o_row_nxt;
  logic                o_rend_r, o_rend_nxt, o_fend_r, o_fend_nxt;

  logic [AW:0]       w_c;
  logic [DIM_W-1:0]  h_c;
  logic [STEP_W-1:0] cs_c, rs_c;
  logic              last_col, last_row;
  logic [STEP_W:0]   rp_sum, cp_sum;
  logic [SUM_W-1:0]  colval;
  logic [GSUM_W-1:0] gs_new;
  logic [GCNT_W-1:0] gc_new;
  logic              fire, emit_ok, rend;
  logic [GCNT_W:0]   shifted;
  logic              ge;

  always_comb begin
    if (src_w_r == '0)                          w_c = (AW+1)'(1);
    else if (32'(src_w_r) > 32'(MAX_WIDTH))     w_c = (AW+1)'(MAX_WIDTH);
    else                                        w_c = (AW+1)'(src_w_r);
    if (src_h_r == '0)                          h_c = DIM_W'(1);
    else if (32'(src_h_r) > 32'(MAX_HEIGHT))    h_c = DIM_W'(MAX_HEIGHT);
    else                                        h_c = src_h_r;
    cs_c     = (col_step_r > PHASE_ONE) ? PHASE_ONE : col_step_r;
    rs_c     = (row_step_r > PHASE_ONE) ? PHASE_ONE : row_step_r;
    last_col = ({1'b0, src_col_r} + (AW+1)'(1)) >= w_c;
    last_row = (DIM_W'(src_row_r) + DIM_W'(1)) >= h_c;
  end

  assign ram_raddr = src_col_r;

  always_comb begin
    src_w_nxt = src_w_r; src_h_nxt = src_h_r; dst_w_nxt = dst_w_r; dst_h_nxt = dst_h_r;
    col_step_nxt = col_step_r; row_step_nxt = row_step_r;
    px_nxt = px_r; row_phase_nxt = row_phase_r; col_phase_nxt = col_phase_r;
    src_col_nxt = src_col_r; src_row_nxt = src_row_r; band_nxt = band_r;
    gsum_nxt = gsum_r; gcnt_nxt = gcnt_r; dst_col_nxt = dst_col_r; dst_row_nxt = dst_row_r;
    closes_nxt = closes_r;
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r;
    m_col_nxt = m_col_r; m_row_nxt = m_row_r; m_rend_nxt = m_rend_r; m_fend_nxt = m_fend_r;
    out_valid_nxt = out_valid_r; o_pix_nxt = o_pix_r; o_col_nxt = o_col_r;
    o_row_nxt = o_row_r; o_rend_nxt = o_rend_r; o_fend_nxt = o_fend_r;
    ram_we = 1'b0; ram_waddr = src_col_r; ram_wdata = '0;
    rp_sum = '0; cp_sum = '0; colval = '0; gs_new = '0; gc_new = '0;
    fire = 1'b0; emit_ok = 1'b0; rend = 1'b0; shifted = '0; ge = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_w_nxt    = cfg_data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_nxt    = cfg_data[DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_nxt    = cfg_data[DIM_W-1:0];
        REG_DST_HEIGHT: dst_h_nxt    = cfg_data[DIM_W-1:0];
        REG_COL_STEP:   col_step_nxt = cfg_data[STEP_W-1:0];
        REG_ROW_STEP:   row_step_nxt = cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end

    if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.clear_addr;
    end

    // Latch each accepted pixel; at the start of a source row also latch the band decision and restart the row.
    if (cmd.accept) begin
      px_nxt = in_pixel;
      if (src_col_r == '0) begin
        rp_sum     = {1'b0, row_phase_r} + {1'b0, rs_c};
        closes_nxt = last_row;
        if (rp_sum >= {1'b0, PHASE_ONE}) begin
          rp_sum     = rp_sum - {1'b0, PHASE_ONE};
          closes_nxt = 1'b1;
        end
        row_phase_nxt = rp_sum[STEP_W-1:0];
        col_phase_nxt = cs_c >> 1;
        gsum_nxt      = '0;
        gcnt_nxt      = '0;
        dst_col_nxt   = '0;
      end
    end

    if (cmd.exec) begin
      colval = ram_rdata + SUM_W'(px_r);
      ram_we = 1'b1;
      if (closes_r) begin
        ram_wdata     = '0;
        gs_new        = gsum_r + GSUM_W'(colval);
        gc_new        = gcnt_r + GCNT_W'(band_r) + GCNT_W'(1);
        gsum_nxt      = gs_new;
        gcnt_nxt      = gc_new;
        cp_sum        = {1'b0, col_phase_r} + {1'b0, cs_c};
        col_phase_nxt = cp_sum[STEP_W-1:0];
        if (last_col) begin
          fire = 1'b1;
        end else if (cp_sum >= {1'b0, PHASE_ONE}) begin
          col_phase_nxt = cp_sum[STEP_W-1:0] - PHASE_ONE;
          fire          = 1'b1;
        end
        if (fire) begin
          emit_ok = (dst_row_r < dst_h_r) && (dst_col_r < dst_w_r);
          rend    = last_col || (({1'b0, dst_col_r} + (DIM_W+1)'(1)) == {1'b0, dst_w_r});
          if (emit_ok) begin
            num_nxt    = gs_new + GSUM_W'(gc_new >> 1);
            den_nxt    = gc_new;
            rem_nxt    = '0;
            m_col_nxt  = dst_col_r[OCOORD_W-1:0];
            m_row_nxt  = dst_row_r[OCOORD_W-1:0];
            m_rend_nxt = rend;
            m_fend_nxt = rend && (last_row ||
                         (({1'b0, dst_row_r} + (DIM_W+1)'(1)) == {1'b0, dst_h_r}));
          end
          if (dst_col_r < dst_w_r) dst_col_nxt = dst_col_r + DIM_W'(1);
          gsum_nxt = '0;
          gcnt_nxt = '0;
        end
      end else begin
        ram_wdata = colval;
      end

      if (last_col) begin
        src_col_nxt = '0;
        if (closes_r) begin
          band_nxt = '0;
          if (dst_row_r < dst_h_r) dst_row_nxt = dst_row_r + DIM_W'(1);
        end else begin
          band_nxt = band_r + BAND_W'(1);
        end
        if (last_row) begin
          src_row_nxt   = '0;
          row_phase_nxt = rs_c >> 1;
          band_nxt      = '0;
          dst_row_nxt   = '0;
        end else begin
          src_row_nxt = src_row_r + ROW_W'(1);
        end
      end else begin
        src_col_nxt = src_col_r + AW'(1);
      end
    end

    // Restoring divide, one quotient bit per step.
    if (cmd.div_step) begin
      shifted = {rem_r, num_r[GSUM_W-1]};
      ge      = shifted >= {1'b0, den_r};
      rem_nxt = ge ? GCNT_W'(shifted - {1'b0, den_r}) : shifted[GCNT_W-1:0];
      num_nxt = {num_r[GSUM_W-2:0], ge};
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      o_pix_nxt     = (den_r == '0) ? '0 : num_r[PIX_W-1:0];
      o_col_nxt     = m_col_r;
      o_row_nxt     = m_row_r;
      o_rend_nxt    = m_rend_r;
      o_fend_nxt    = m_fend_r;
    end
  end

  assign stat.emit     = cmd.exec && fire && emit_ok;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_pixel = o_pix_r;
  assign out_col   = o_col_r;
  assign out_row   = o_row_r;
  assign row_end   = o_rend_r;
  assign frame_end = o_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r     <= DIM_W'(640);
      src_h_r     <= DIM_W'(480);
      dst_w_r     <= DIM_W'(320);
      dst_h_r     <= DIM_W'(240);
      col_step_r  <= STEP_W'(65536);
      row_step_r  <= STEP_W'(65536);
      row_phase_r <= STEP_W'(32768);
      col_phase_r <= STEP_W'(32768);
      src_col_r   <= '0;
      src_row_r   <= '0;
      band_r      <= '0;
      gsum_r      <= '0;
      gcnt_r      <= '0;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      closes_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      src_w_r     <= src_w_nxt;
      src_h_r     <= src_h_nxt;
      dst_w_r     <= dst_w_nxt;
      dst_h_r     <= dst_h_nxt;
      col_step_r  <= col_step_nxt;
      row_step_r  <= row_step_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      band_r      <= band_nxt;
      gsum_r      <= gsum_nxt;
      gcnt_r      <= gcnt_nxt;
      dst_col_r   <= dst_col_nxt;
      dst_row_r   <= dst_row_nxt;
      closes_r    <= closes_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r     <= px_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    m_col_r  <= m_col_nxt;
    m_row_r  <= m_row_nxt;
    m_rend_r <= m_rend_nxt;
    m_fend_r <= m_fend_nxt;
    o_pix_r  <= o_pix_nxt;
    o_col_r  <= o_col_nxt;
    o_row_r  <= o_row_nxt;
    o_rend_r <= o_rend_nxt;
    o_fend_r <= o_fend_nxt;
  end

endmodule

// ===== design/byte_box_downscale.sv =====
// Sequence: a pixel that closes no box is accepted, then its column store entry is read,
// updated and written back; a pixel that closes a box then also runs the 32-step
// bit-serial divider and waits for the result register to drain before its result loads.
// The block takes no new pixel until it is through with the last one.
// Reset (rst_n low, synchronous): registers return to 640x480 -> 320x240, step 65536;
// afterwards the column store is zeroed over all 4096 entries, during which no pixel is taken.
module byte_box_downscale (
  input logic      clk,
  input logic      rst_n,
  bbd_in_if.sink   in_s,
  bbd_out_if.source out_m,
  bbd_cfg_if.sink  cfg_s
);
  import bbd_pkg::*;

  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  // Config is always taken; software must write only while idle, unchecked by the block.
  assign cfg_s.ready = 1'b1;

  // Sequencer: clearing pass, accept, column update, divide, hand over.
  bbd_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .stat     (stat),
    .in_ready (in_s.ready),
    .cmd      (cmd)
  );

  // Phase accumulators, box sums, divider and result register.
  bbd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_pixel  (in_s.pixel),
    .cfg_we    (cfg_s.valid),
    .cfg_index (cfg_s.index),
    .cfg_data  (cfg_s.data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_m.valid),
    .out_ready (out_m.ready),
    .out_pixel (out_m.out_pixel),
    .out_col   (out_m.out_col),
    .out_row   (out_m.out_row),
    .row_end   (out_m.row_end),
    .frame_end (out_m.frame_end)
  );

  // Column sums of the open band, one entry per source column.
  bbd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/bbd_checker.sv =====
module bbd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bbd_pkg::PIX_W-1:0]    out_pixel,
  input logic [bbd_pkg::OCOORD_W-1:0] out_col,
  input logic                         row_end,
  input logic                         frame_end
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel taken while previous pixel still in work");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_col))
    else $error("result changed while stalled");

endmodule

bind byte_box_downscale bbd_checker u_bbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_pixel (out_m.out_pixel),
  .out_col   (out_m.out_col),
  .row_end   (out_m.row_end),
  .frame_end (out_m.frame_end)
);

// ===== test/tb_byte_box_downscale.sv =====
module tb_byte_box_downscale;
  timeunit 1ns;
  timeprecision 1ps;

  import bbd_pkg::*;

  // Cycles let pass after the last expected box mean before touching the registers:
  // a pixel that closes no box still needs its update in the column store,
  // and one that closes a box needs the divider.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PIXELS = 1080;

  typedef struct {
    logic [PIX_W-1:0]    mean;
    logic [OCOORD_W-1:0] col;
    logic [OCOORD_W-1:0] row;
    logic                row_end;
    logic                frame_end;
  } box_mean_t;

  logic clk;
  logic rst_n;

  bbd_in_if  pix_if ();
  bbd_out_if box_if ();
  bbd_cfg_if reg_if ();

  byte_box_downscale dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (pix_if.sink),
    .out_m (box_if.source),
    .cfg_s (reg_if.sink)
  );

  // Shadow of the downscaler: registers, column store and the phase counters.
  int unsigned       reg_shadow [6];
  logic [SUM_W-1:0]  col_sums [MAX_WIDTH];
  int unsigned       row_phase, col_phase;
  int unsigned       src_col, src_row, band_rows;
  int unsigned       grp_sum, grp_count;
  int unsigned       dst_col, dst_row;
  bit                band_closing;

  box_mean_t   expected_means [$];
  int          mismatches;
  int          means_seen;
  int          pixels_sent;
  int          frames_sent;
  int unsigned cycle_count;
  int          burst_left;

  // Clock and watchdog
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d box means outstanding", cycle_count,
               expected_means.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_step(int unsigned v);
    return (v > PHASE_ONE) ? PHASE_ONE : v;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic reset_shadow();
    reg_shadow[REG_SRC_WIDTH]  = 640;
    reg_shadow[REG_SRC_HEIGHT] = 480;
    reg_shadow[REG_DST_WIDTH]  = 320;
    reg_shadow[REG_DST_HEIGHT] = 240;
    reg_shadow[REG_COL_STEP]   = 65536;
    reg_shadow[REG_ROW_STEP]   = 65536;
    foreach (col_sums[i]) col_sums[i] = '0;
    row_phase    = clamp_step(reg_shadow[REG_ROW_STEP]) / 2;
    col_phase    = clamp_step(reg_shadow[REG_COL_STEP]) / 2;
    src_col      = 0;
    src_row      = 0;
    band_rows    = 0;
    grp_sum      = 0;
    grp_count    = 0;
    dst_col      = 0;
    dst_row      = 0;
    band_closing = 1'b0;
  endtask

  // Advance the shadow by one accepted pixel; queue the box mean it completes, if any.
  task automatic predict_box_mean(input logic [PIX_W-1:0] px);
    int unsigned w, h, dw, dh, cs, rs, idx, colval;
    bit          last_row, last_col, fire;
    box_mean_t   m;
    w  = clamp_dim(reg_shadow[REG_SRC_WIDTH], MAX_WIDTH);
    h  = clamp_dim(reg_shadow[REG_SRC_HEIGHT], MAX_HEIGHT);
    dw = reg_shadow[REG_DST_WIDTH];
    dh = reg_shadow[REG_DST_HEIGHT];
    cs = clamp_step(reg_shadow[REG_COL_STEP]);
    rs = clamp_step(reg_shadow[REG_ROW_STEP]);
    last_row = (src_row + 1 >= h);
    last_col = (src_col + 1 >= w);
    idx = (src_col < MAX_WIDTH) ? src_col : MAX_WIDTH - 1;

    // The band decision is latched at the first pixel of each source row
    if (src_col == 0) begin
      row_phase    = row_phase + rs;
      band_closing = last_row;
      if (row_phase >= PHASE_ONE) begin
        row_phase    = row_phase - PHASE_ONE;
        band_closing = 1'b1;
      end
      col_phase = cs / 2;
      grp_sum   = 0;
      grp_count = 0;
      dst_col   = 0;
    end

    if (band_closing) begin
      colval        = (int'(col_sums[idx]) + px) & 32'hFFFF;
      col_sums[idx] = '0;
      fire          = 1'b0;
      grp_sum       = grp_sum + colval;
      grp_count     = (grp_count + band_rows + 1) & 32'h1FF_FFFF;
      col_phase     = col_phase + cs;
      if (last_col) begin
        fire = 1'b1;
      end else if (col_phase >= PHASE_ONE) begin
        col_phase = col_phase - PHASE_ONE;
        fire      = 1'b1;
      end
      if (fire) begin
        if (dst_row < dh && dst_col < dw) begin
          m.mean      = (grp_count != 0) ? PIX_W'((grp_sum + grp_count / 2) / grp_count) : '0;
          m.col       = OCOORD_W'(dst_col);
          m.row       = OCOORD_W'(dst_row);
          m.row_end   = last_col || (dst_col + 1 == dw);
          m.frame_end = m.row_end && (last_row || (dst_row + 1 == dh));
          expected_means.push_back(m);
        end
        if (dst_col < dw) dst_col++;
        grp_sum   = 0;
        grp_count = 0;
      end
    end else begin
      col_sums[idx] = col_sums[idx] + SUM_W'(px);
    end

    if (last_col) begin
      src_col = 0;
      if (band_closing) begin
        band_rows = 0;
        if (dst_row < dh) dst_row++;
      end else begin
        band_rows = (band_rows + 1) & 32'h1FFF;
      end
      if (last_row) begin
        src_row   = 0;
        row_phase = rs / 2;
        band_rows = 0;
        dst_row   = 0;
        frames_sent++;
      end else begin
        src_row++;
      end
    end else begin
      src_col++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Result checker: compare every transaction on the output against the oldest prediction
  always @(posedge clk) begin
    box_mean_t want;
    if (rst_n && box_if.valid && box_if.ready) begin
      means_seen++;
      if (expected_means.size() == 0) begin
        mismatches++;
        $display("[%0t] unexpected box mean at col %0d row %0d", $realtime,
                 box_if.out_col, box_if.out_row);
      end else begin
        want = expected_means.pop_front();
        if (box_if.out_pixel !== want.mean)
          report_mismatch("out_pixel", box_if.out_pixel, want.mean);
        if (box_if.out_col !== want.col)
          report_mismatch("out_col", box_if.out_col, want.col);
        if (box_if.out_row !== want.row)
          report_mismatch("out_row", box_if.out_row, want.row);
        if (box_if.row_end !== want.row_end)
          report_mismatch("row_end", box_if.row_end, want.row_end);
        if (box_if.frame_end !== want.frame_end)
          report_mismatch("frame_end", box_if.frame_end, want.frame_end);
      end
    end
  end

  // Receiver back-pressure: switch between always ready, random stalls and long stalls
  int unsigned stall_tick;
  int unsigned stall_mode;
  always @(negedge clk) begin
    if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
    stall_tick++;
    case (stall_mode)
      0:       box_if.ready = 1'b1;
      1:       box_if.ready = $urandom_range(0, 1);
      2:       box_if.ready = (stall_tick % 23) < 5;
      default: box_if.ready = ($urandom_range(0, 7) != 0);
    endcase
  end

  // Register write; hold valid until the handshake completes
  task automatic write_reg(input cfg_reg_t r, input int unsigned value);
    reg_if.valid = 1'b1;
    reg_if.index = r;
    reg_if.data  = CDATA_W'(value);
    do @(posedge clk); while (!reg_if.ready);
    reg_shadow[r] = value & ((r == REG_COL_STEP || r == REG_ROW_STEP) ? 32'h3FFFF : 32'h1FFF);
    @(negedge clk);
    reg_if.valid = 1'b0;
  endtask

  // Send one pixel; bursts of random length with random gaps in between
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 2) != 0) begin
        pix_if.valid = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    pix_if.valid = 1'b1;
    pix_if.pixel = px;
    do @(posedge clk); while (!pix_if.ready);
    predict_box_mean(px);
    pixels_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Run pixels until the shadow is back at the start of a frame
  task automatic send_rest_of_frame();
    do send_pixel(random_pixel()); while (src_col != 0 || src_row != 0);
  endtask

  // Hold off until every expected mean is back and the block has settled
  task automatic drain();
    pix_if.valid = 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned sw, input int unsigned sh,
                              input int unsigned dw, input int unsigned dh,
                              input int unsigned cs, input int unsigned rs);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_COL_STEP, cs);
    write_reg(REG_ROW_STEP, rs);
  endtask

  // Small hand-made frames: extremes of pixel values, clamped steps, empty destination, zero source width
  task automatic test_directed_frames();
    // 4x4 -> 2x2, half-scale, pixels in a black and white checkerboard
    set_geometry(4, 4, 2, 2, 65536, 65536);
    for (int i = 0; i < 16; i++)
      send_pixel(((i + i / 4) % 2) ? 8'hFF : 8'h00);
    drain();
    // single pixel frame with both steps beyond one
    set_geometry(1, 1, 1, 1, 32'h3FFFF, 32'h3FFFF);
    send_pixel(8'hFF);
    drain();
    // zero destination size: nothing may come out
    set_geometry(2, 2, 0, 0, 0, 0);
    repeat (4) send_pixel(8'hA5);
    drain();
    // zero source width acts as one column
    set_geometry(0, 1, 1, 1, 131072, 131072);
    send_pixel(8'h5A);
    drain();
  endtask

  // Random geometries, mostly with the steps software would compute
  task automatic test_random_frames();
    int unsigned sw, sh, dw, dh, cs, rs;
    int          target;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      sw = $urandom_range(1, 24);
      sh = $urandom_range(1, 10);
      dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sw + 3) : $urandom_range(1, sw);
      dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sh + 3) : $urandom_range(1, sh);
      cs = (131072 * dw) / sw;
      rs = (131072 * dh) / sh;
      if ($urandom_range(0, 7) == 0) cs = $urandom_range(0, 32'h3FFFF);
      if ($urandom_range(0, 7) == 0) rs = $urandom_range(0, 32'h3FFFF);
      set_geometry(sw, sh, dw, dh, cs, rs);
      send_rest_of_frame();
      drain();
    end
  endtask

  // Tall single column of white in one band: column sums wrap at 16 bits
  task automatic test_column_sum_wrap();
    set_geometry(1, 300, 1, 1, 131072, 0);
    repeat (300) send_pixel(8'hFF);
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    box_if.ready = 1'b0;
    reg_if.valid = 1'b0;
    reg_if.index = '0;
    reg_if.data  = '0;
    cycle_count  = 0;
    mismatches   = 0;
    means_seen   = 0;
    pixels_sent  = 0;
    frames_sent  = 0;
    burst_left   = 0;
    stall_tick   = 0;
    stall_mode   = 0;
    reset_shadow();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_column_sum_wrap();
    test_random_frames();

    drain();
    $display("covered %0d source pixels in %0d frames, %0d box means checked",
             pixels_sent, frames_sent, means_seen);
    $display("geometries: directed, random small, 16-bit sum wrap");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== byte_box_downscale.f =====
design/bbd_pkg.sv
design/bbd_ifs.sv
design/bbd_ram.sv
design/bbd_ctl.sv
design/bbd_dp.sv
design/byte_box_downscale.sv
design/bbd_checker.sv
test/tb_byte_box_downscale.sv
